/* rtl/ssos_pkg.sv */
package ssos_pkg;

	// Default width of the distance path
	localparam int DIST_W_DEF = 12;

	// Register widths fixed by the register map
	localparam int ANGLE_W  = 8;
	localparam int TICK_W   = 8;
	localparam int MARGIN_W = 8;
	localparam int CLEAR_W  = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 3'd5;

	// Register reset values
	localparam logic [ANGLE_W-1:0]  CENTER_RST = 8'd90;
	localparam logic [ANGLE_W-1:0]  LEFT_RST   = 8'd145;
	localparam logic [ANGLE_W-1:0]  RIGHT_RST  = 8'd35;
	localparam logic [TICK_W-1:0]   SETTLE_RST = 8'd15;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd10;
	localparam logic [CLEAR_W-1:0]  CLEAR_RST  = 12'd25;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// Direction codes
	localparam logic [2:0] DIR_NONE    = 3'd0;
	localparam logic [2:0] DIR_LEFT    = 3'd1;
	localparam logic [2:0] DIR_RIGHT   = 3'd2;
	localparam logic [2:0] DIR_BLOCKED = 3'd3;
	localparam logic [2:0] DIR_UNKNOWN = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_C_MOVE = 4'd1,
		PH_C_WAIT = 4'd2,
		PH_C_SAMP = 4'd3,
		PH_L_MOVE = 4'd4,
		PH_L_WAIT = 4'd5,
		PH_L_SAMP = 4'd6,
		PH_R_MOVE = 4'd7,
		PH_R_WAIT = 4'd8,
		PH_R_SAMP = 4'd9,
		PH_RETURN = 4'd10,
		PH_DONE   = 4'd11
	} phase_t;

	// Reported phase for the complete hold
	localparam logic [3:0] PHASE_SHOWN_DONE = 4'd10;

	typedef struct packed {
		logic [ANGLE_W-1:0]  center_angle;
		logic [ANGLE_W-1:0]  left_angle;
		logic [ANGLE_W-1:0]  right_angle;
		logic [TICK_W-1:0]   settle_ticks;
		logic [MARGIN_W-1:0] side_margin;
		logic [CLEAR_W-1:0]  min_clear;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [TICK_W-1:0]  settle_count;
		logic [ANGLE_W-1:0] servo_cmd;
		logic               active;
		logic               complete;
		logic [2:0]         dir_code;
	} ctrl_t;

endpackage

/* rtl/ssos_step.sv */
// Next state of the scanner for one tick
module ssos_step import ssos_pkg::*; #(
	parameter int DISTANCE_WIDTH = DIST_W_DEF
) (
	input  cfg_t                      cfg,
	input  ctrl_t                     ctrl_q,
	input  logic [DISTANCE_WIDTH-1:0] dist_q [3],
	input  logic                      ok_q [3],
	input  logic                      holding,
	input  logic                      reading_valid,
	input  logic [DISTANCE_WIDTH-1:0] reading_cm,
	output ctrl_t                     ctrl_d,
	output logic [DISTANCE_WIDTH-1:0] dist_d [3],
	output logic                      ok_d [3]
);

	localparam int CMP_W = (DISTANCE_WIDTH > CLEAR_W) ? DISTANCE_WIDTH : CLEAR_W;

	logic [DISTANCE_WIDTH-1:0] sample;
	logic [TICK_W-1:0]         tick_inc;
	logic                      settled;
	phase_t                    phase_nx;
	logic [TICK_W-1:0]         settle_nx;
	logic [ANGLE_W-1:0]        servo_nx;
	logic                      active_nx;
	logic                      complete_nx;
	logic [2:0]                dir_nx;
	logic [2:0]                dir_pick;
	logic [DISTANCE_WIDTH:0]   l_ext, r_ext, l_sum, r_sum;
	logic                      l_low, r_low;

	assign sample   = reading_valid ? reading_cm : '0;
	assign tick_inc = (ctrl_q.settle_count < TICK_MAX) ? ctrl_q.settle_count + 1'b1
	                                                   : ctrl_q.settle_count;
	assign settled  = (tick_inc >= cfg.settle_ticks);

	// Direction from the left capture and the right sample taken this tick
	assign l_ext = {1'b0, dist_q[1]};
	assign r_ext = {1'b0, sample};
	assign l_sum = l_ext + (DISTANCE_WIDTH+1)'(cfg.side_margin);
	assign r_sum = r_ext + (DISTANCE_WIDTH+1)'(cfg.side_margin);
	assign l_low = CMP_W'(dist_q[1]) < CMP_W'(cfg.min_clear);
	assign r_low = CMP_W'(sample) < CMP_W'(cfg.min_clear);

	always_comb begin
		if (!ok_q[1] || !reading_valid) begin
			dir_pick = DIR_UNKNOWN;
		end else if (l_low && r_low) begin
			dir_pick = DIR_BLOCKED;
		end else if (l_ext >= r_sum) begin
			dir_pick = DIR_LEFT;
		end else if (r_ext >= l_sum) begin
			dir_pick = DIR_RIGHT;
		end else begin
			dir_pick = DIR_UNKNOWN;
		end
	end

	// Phase sequencing and settle counter
	always_comb begin
		phase_nx  = ctrl_q.phase;
		settle_nx = ctrl_q.settle_count;
		if (!holding) begin
			phase_nx  = PH_IDLE;
			settle_nx = '0;
		end else begin
			case (ctrl_q.phase)
				PH_IDLE: begin
					phase_nx  = PH_C_MOVE;
					settle_nx = '0;
				end
				PH_C_MOVE: begin
					phase_nx  = PH_C_WAIT;
					settle_nx = '0;
				end
				PH_L_MOVE: begin
					phase_nx  = PH_L_WAIT;
					settle_nx = '0;
				end
				PH_R_MOVE: begin
					phase_nx  = PH_R_WAIT;
					settle_nx = '0;
				end
				PH_C_WAIT, PH_L_WAIT, PH_R_WAIT: begin
					if (settled) begin
						settle_nx = '0;
						case (ctrl_q.phase)
							PH_C_WAIT: phase_nx = PH_C_SAMP;
							PH_L_WAIT: phase_nx = PH_L_SAMP;
							default:   phase_nx = PH_R_SAMP;
						endcase
					end else begin
						settle_nx = tick_inc;
					end
				end
				PH_C_SAMP: begin
					phase_nx  = PH_L_MOVE;
					settle_nx = '0;
				end
				PH_L_SAMP: begin
					phase_nx  = PH_R_MOVE;
					settle_nx = '0;
				end
				PH_R_SAMP: begin
					phase_nx  = PH_RETURN;
					settle_nx = '0;
				end
				PH_RETURN: begin
					phase_nx  = PH_DONE;
					settle_nx = '0;
				end
				default: ;
			endcase
		end
	end

	// Servo command, flags and captures
	always_comb begin
		servo_nx    = ctrl_q.servo_cmd;
		active_nx   = ctrl_q.active;
		complete_nx = ctrl_q.complete;
		dir_nx      = ctrl_q.dir_code;
		dist_d      = dist_q;
		ok_d        = ok_q;
		if (!holding) begin
			servo_nx    = cfg.center_angle;
			active_nx   = 1'b0;
			complete_nx = 1'b0;
			dir_nx      = DIR_NONE;
			dist_d      = '{default: '0};
			ok_d        = '{default: 1'b0};
		end else begin
			case (ctrl_q.phase)
				PH_IDLE: begin
					active_nx   = 1'b1;
					complete_nx = 1'b0;
					dir_nx      = DIR_NONE;
					dist_d      = '{default: '0};
					ok_d        = '{default: 1'b0};
				end
				PH_C_MOVE: servo_nx = cfg.center_angle;
				PH_L_MOVE: servo_nx = cfg.left_angle;
				PH_R_MOVE: servo_nx = cfg.right_angle;
				PH_C_WAIT, PH_L_WAIT, PH_R_WAIT: ;
				PH_C_SAMP: begin
					dist_d[0] = sample;
					ok_d[0]   = reading_valid;
				end
				PH_L_SAMP: begin
					dist_d[1] = sample;
					ok_d[1]   = reading_valid;
				end
				PH_R_SAMP: begin
					dist_d[2] = sample;
					ok_d[2]   = reading_valid;
					dir_nx    = dir_pick;
				end
				PH_RETURN: begin
					servo_nx    = cfg.center_angle;
					complete_nx = 1'b1;
					active_nx   = 1'b0;
				end
				default: servo_nx = cfg.center_angle;
			endcase
		end
	end

	assign ctrl_d = '{phase:        phase_nx,
	                  settle_count: settle_nx,
	                  servo_cmd:    servo_nx,
	                  active:       active_nx,
	                  complete:     complete_nx,
	                  dir_code:     dir_nx};

endmodule

/* rtl/servo_sweep_obstacle_scanner_core.sv */
// Servo sweep obstacle scanner.
//
// Input channel (in_valid / in_stall): one word per control tick carrying
// holding, reading_valid and reading_cm. While holding is high the block
// steps the servo through center, left and right, waits settle_ticks at each
// position, captures the distance and then recommends a direction.
// Output channel (out_valid / out_stall): one word per input word with the
// servo target, phase, flags, direction and the three captures as they
// stand after that tick.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; angle and tick registers take the low 8 bits of cfg_data.
// From input accept to result a word passes the input register, then the
// tick logic updates the state register, which is also the result register.
// Throughput is one word per cycle while the receiver does not stall.
// Reset clears the scan state to idle with the servo at 90 degrees and the
// registers to their defaults; no word is pending after reset.
// When the receiver stalls a valid result, the result holds, a word in the input
// register stays there and in_stall rises, so at most one word waits on each side.
module servo_sweep_obstacle_scanner_core import ssos_pkg::*; #(
	parameter int DISTANCE_WIDTH = DIST_W_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      holding,
	input  logic                      reading_valid,
	input  logic [DISTANCE_WIDTH-1:0] reading_cm,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ANGLE_W-1:0]        servo_target,
	output logic [3:0]                scan_phase,
	output logic                      scan_active,
	output logic                      scan_complete,
	output logic [2:0]                direction,
	output logic [DISTANCE_WIDTH-1:0] center_cm,
	output logic                      center_ok,
	output logic [DISTANCE_WIDTH-1:0] left_cm,
	output logic                      left_ok,
	output logic [DISTANCE_WIDTH-1:0] right_cm,
	output logic                      right_ok
);

	cfg_t                      cfg_q;
	ctrl_t                     ctrl_q, ctrl_d;
	logic [DISTANCE_WIDTH-1:0] dist_q [3];
	logic [DISTANCE_WIDTH-1:0] dist_d [3];
	logic                      ok_q [3];
	logic                      ok_d [3];
	logic                      valid_s1;
	logic                      holding_s1;
	logic                      rvalid_s1;
	logic [DISTANCE_WIDTH-1:0] rcm_s1;
	logic                      out_valid_q;
	logic                      advance;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_angle <= CENTER_RST;
			cfg_q.left_angle   <= LEFT_RST;
			cfg_q.right_angle  <= RIGHT_RST;
			cfg_q.settle_ticks <= SETTLE_RST;
			cfg_q.side_margin  <= MARGIN_RST;
			cfg_q.min_clear    <= CLEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTER: cfg_q.center_angle <= cfg_data[ANGLE_W-1:0];
				CFG_LEFT:   cfg_q.left_angle   <= cfg_data[ANGLE_W-1:0];
				CFG_RIGHT:  cfg_q.right_angle  <= cfg_data[ANGLE_W-1:0];
				CFG_SETTLE: cfg_q.settle_ticks <= cfg_data[TICK_W-1:0];
				CFG_MARGIN: cfg_q.side_margin  <= cfg_data[MARGIN_W-1:0];
				CFG_CLEAR:  cfg_q.min_clear    <= cfg_data[CLEAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the tick advances when the result slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			holding_s1 <= holding;
			rvalid_s1  <= reading_valid;
			rcm_s1     <= reading_cm;
		end
	end

	ssos_step #(
		.DISTANCE_WIDTH(DISTANCE_WIDTH)
	) u_step (
		.cfg          (cfg_q),
		.ctrl_q       (ctrl_q),
		.dist_q       (dist_q),
		.ok_q         (ok_q),
		.holding      (holding_s1),
		.reading_valid(rvalid_s1),
		.reading_cm   (rcm_s1),
		.ctrl_d       (ctrl_d),
		.dist_d       (dist_d),
		.ok_d         (ok_d)
	);

	// Scan state, which doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.phase        <= PH_IDLE;
			ctrl_q.settle_count <= '0;
			ctrl_q.servo_cmd    <= CENTER_RST;
			ctrl_q.active       <= 1'b0;
			ctrl_q.complete     <= 1'b0;
			ctrl_q.dir_code     <= DIR_NONE;
			dist_q              <= '{default: '0};
			ok_q                <= '{default: 1'b0};
		end else if (advance) begin
			ctrl_q <= ctrl_d;
			dist_q <= dist_d;
			ok_q   <= ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result fields
	assign out_valid     = out_valid_q;
	assign servo_target  = ctrl_q.servo_cmd;
	assign scan_phase    = (ctrl_q.phase == PH_DONE) ? PHASE_SHOWN_DONE : ctrl_q.phase;
	assign scan_active   = ctrl_q.active;
	assign scan_complete = ctrl_q.complete;
	assign direction     = ctrl_q.dir_code;
	assign center_cm     = dist_q[0];
	assign center_ok     = ok_q[0];
	assign left_cm       = dist_q[1];
	assign left_ok       = ok_q[1];
	assign right_cm      = dist_q[2];
	assign right_ok      = ok_q[2];

	// Checks
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_q.active && ctrl_q.complete))
		else $error("scan active and complete at once");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q.phase == PH_IDLE) |-> (!ctrl_q.active && !ctrl_q.complete))
		else $error("flags set while idle");

	a_dir_late: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q.dir_code != DIR_NONE) |->
			(ctrl_q.phase == PH_RETURN || ctrl_q.phase == PH_DONE))
		else $error("direction set before the right capture");

	a_release_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !holding_s1) |=> (ctrl_q.phase == PH_IDLE && ctrl_q.dir_code == DIR_NONE))
		else $error("hold release did not idle the scan");

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with nothing pending");

endmodule

/* dv/ssos_scan_checker.sv */
`timescale 1ns / 100ps

// Scoreboard for the scanner: tracks register writes, predicts one result
// word per accepted input word and compares it with the output channel.
module ssos_scan_checker import ssos_pkg::*; #(
	parameter int DW = DIST_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 holding,
	input  logic                 reading_valid,
	input  logic [DW-1:0]        reading_cm,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [ANGLE_W-1:0]   servo_target,
	input  logic [3:0]           scan_phase,
	input  logic                 scan_active,
	input  logic                 scan_complete,
	input  logic [2:0]           direction,
	input  logic [DW-1:0]        center_cm,
	input  logic                 center_ok,
	input  logic [DW-1:0]        left_cm,
	input  logic                 left_ok,
	input  logic [DW-1:0]        right_cm,
	input  logic                 right_ok,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [ANGLE_W-1:0] servo;
		logic [3:0]         phase;
		logic               active;
		logic               complete;
		logic [2:0]         dir;
		logic [DW-1:0]      c_cm;
		logic               c_ok;
		logic [DW-1:0]      l_cm;
		logic               l_ok;
		logic [DW-1:0]      r_cm;
		logic               r_ok;
	} scan_word_t;

	// shadow registers and scan state
	cfg_t          regs;
	ctrl_t         st;
	logic [DW-1:0] cap_cm [3];
	logic          cap_ok [3];

	scan_word_t awaited_words [$];
	int         errs;

	task automatic report_mismatch(input string what, input int got, input int want);
		errs++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic void clear_captures();
		st.dir_code = DIR_NONE;
		st.active   = 1'b0;
		st.complete = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cap_cm[i] = '0;
			cap_ok[i] = 1'b0;
		end
	endfunction

	function automatic void enter_phase(input phase_t p);
		st.phase        = p;
		st.settle_count = '0;
	endfunction

	// direction recommendation; margin sums are taken at full int width
	function automatic void pick_direction();
		int l;
		int r;
		l = int'(cap_cm[1]);
		r = int'(cap_cm[2]);
		if (!cap_ok[1] || !cap_ok[2])
			st.dir_code = DIR_UNKNOWN;
		else if (l < int'(regs.min_clear) && r < int'(regs.min_clear))
			st.dir_code = DIR_BLOCKED;
		else if (l >= r + int'(regs.side_margin))
			st.dir_code = DIR_LEFT;
		else if (r >= l + int'(regs.side_margin))
			st.dir_code = DIR_RIGHT;
		else
			st.dir_code = DIR_UNKNOWN;
	endfunction

	// one control tick of the scanner, returns the word it reports
	function automatic scan_word_t scanner_tick(input logic h, input logic v,
			input logic [DW-1:0] cm);
		logic [DW-1:0] sample;
		int            p;
		scan_word_t    w;
		sample = v ? cm : '0;
		if (!h) begin
			clear_captures();
			st.servo_cmd = regs.center_angle;
			enter_phase(PH_IDLE);
		end else begin
			case (st.phase)
				PH_IDLE: begin
					clear_captures();
					st.active = 1'b1;
					enter_phase(PH_C_MOVE);
				end
				PH_C_MOVE: begin
					st.servo_cmd = regs.center_angle;
					enter_phase(PH_C_WAIT);
				end
				PH_L_MOVE: begin
					st.servo_cmd = regs.left_angle;
					enter_phase(PH_L_WAIT);
				end
				PH_R_MOVE: begin
					st.servo_cmd = regs.right_angle;
					enter_phase(PH_R_WAIT);
				end
				PH_C_WAIT, PH_L_WAIT, PH_R_WAIT: begin
					// count saturates; compared after the bump
					if (st.settle_count != TICK_MAX)
						st.settle_count++;
					if (st.settle_count >= regs.settle_ticks)
						enter_phase(phase_t'(st.phase + 4'd1));
				end
				PH_C_SAMP, PH_L_SAMP, PH_R_SAMP: begin
					p = (int'(st.phase) - 3) / 3;
					cap_cm[p] = sample;
					cap_ok[p] = v;
					if (p == 2)
						pick_direction();
					enter_phase(phase_t'(st.phase + 4'd1));
				end
				PH_RETURN: begin
					st.servo_cmd = regs.center_angle;
					st.complete  = 1'b1;
					st.active    = 1'b0;
					enter_phase(PH_DONE);
				end
				default: begin
					// complete hold follows the center register
					st.servo_cmd = regs.center_angle;
				end
			endcase
		end
		w.servo    = st.servo_cmd;
		w.phase    = (st.phase > PH_RETURN) ? PHASE_SHOWN_DONE : 4'(st.phase);
		w.active   = st.active;
		w.complete = st.complete;
		w.dir      = st.dir_code;
		w.c_cm     = cap_cm[0];
		w.c_ok     = cap_ok[0];
		w.l_cm     = cap_cm[1];
		w.l_ok     = cap_ok[1];
		w.r_cm     = cap_cm[2];
		w.r_ok     = cap_ok[2];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_word_t want;
		scan_word_t got;
		if (!arst_n) begin
			regs = '{center_angle: CENTER_RST, left_angle: LEFT_RST,
				right_angle: RIGHT_RST, settle_ticks: SETTLE_RST,
				side_margin: MARGIN_RST, min_clear: CLEAR_RST};
			clear_captures();
			st.servo_cmd = CENTER_RST;
			enter_phase(PH_IDLE);
			awaited_words.delete();
			errs = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CENTER: regs.center_angle = cfg_data[ANGLE_W-1:0];
					CFG_LEFT:   regs.left_angle   = cfg_data[ANGLE_W-1:0];
					CFG_RIGHT:  regs.right_angle  = cfg_data[ANGLE_W-1:0];
					CFG_SETTLE: regs.settle_ticks = cfg_data[TICK_W-1:0];
					CFG_MARGIN: regs.side_margin  = cfg_data[MARGIN_W-1:0];
					CFG_CLEAR:  regs.min_clear    = cfg_data[CLEAR_W-1:0];
					default: ;
				endcase
			end

			// result words against the oldest prediction
			if (out_valid && !out_stall) begin
				got = '{servo_target, scan_phase, scan_active, scan_complete, direction,
					center_cm, center_ok, left_cm, left_ok, right_cm, right_ok};
				if (awaited_words.size() == 0) begin
					report_mismatch("result word with none awaited", 1, 0);
				end else begin
					want = awaited_words.pop_front();
					if (got.servo !== want.servo)
						report_mismatch("servo_target", int'(got.servo), int'(want.servo));
					if (got.phase !== want.phase)
						report_mismatch("scan_phase", int'(got.phase), int'(want.phase));
					if (got.active !== want.active)
						report_mismatch("scan_active", int'(got.active), int'(want.active));
					if (got.complete !== want.complete)
						report_mismatch("scan_complete", int'(got.complete),
							int'(want.complete));
					if (got.dir !== want.dir)
						report_mismatch("direction", int'(got.dir), int'(want.dir));
					if (got.c_cm !== want.c_cm)
						report_mismatch("center_cm", int'(got.c_cm), int'(want.c_cm));
					if (got.c_ok !== want.c_ok)
						report_mismatch("center_ok", int'(got.c_ok), int'(want.c_ok));
					if (got.l_cm !== want.l_cm)
						report_mismatch("left_cm", int'(got.l_cm), int'(want.l_cm));
					if (got.l_ok !== want.l_ok)
						report_mismatch("left_ok", int'(got.l_ok), int'(want.l_ok));
					if (got.r_cm !== want.r_cm)
						report_mismatch("right_cm", int'(got.r_cm), int'(want.r_cm));
					if (got.r_ok !== want.r_ok)
						report_mismatch("right_ok", int'(got.r_ok), int'(want.r_ok));
				end
			end

			// accepted tick
			if (in_valid && !in_stall)
				awaited_words.push_back(scanner_tick(holding, reading_valid, reading_cm));

			fail_count <= errs;
			pending    <= awaited_words.size();
		end
	end

endmodule

/* dv/servo_sweep_obstacle_scanner_core_tb.sv */
`timescale 1ns / 100ps

module servo_sweep_obstacle_scanner_core_tb;
	import ssos_pkg::*;

	localparam int DW = DIST_W_DEF;
	localparam int CM_MAX = (1 << DW) - 1;

	// indexes past the register list, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  holding = 1'b0;
	logic                  reading_valid = 1'b0;
	logic [DW-1:0]         reading_cm = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ANGLE_W-1:0]    servo_target;
	logic [3:0]            scan_phase;
	logic                  scan_active;
	logic                  scan_complete;
	logic [2:0]            direction;
	logic [DW-1:0]         center_cm;
	logic                  center_ok;
	logic [DW-1:0]         left_cm;
	logic                  left_ok;
	logic [DW-1:0]         right_cm;
	logic                  right_ok;
	int                    fail_count;
	int                    pending;

	// settings the stimulus aims at
	int cur_settle = int'(SETTLE_RST);
	int cur_margin = int'(MARGIN_RST);
	int cur_clear  = int'(CLEAR_RST);
	int burst_left = 0;
	int tick_count = 0;

	servo_sweep_obstacle_scanner_core #(.DISTANCE_WIDTH(DW)) dut (.*);

	ssos_scan_checker #(.DW(DW)) u_check (.*);

	always #5 clk = ~clk;

	initial begin
		#(5_000_000);
		$display("[servo_sweep_obstacle_scanner_core] ERROR");
		$finish;
	end

	// receiver stall: duty pattern of random period and duty, re-rolled periodically
	int stall_cycle  = 0;
	int stall_pos    = 0;
	int stall_period = 1;
	int stall_duty   = 0;
	always @(posedge clk) begin
		if (stall_cycle % 64 == 0) begin
			stall_period = $urandom_range(1, 8);
			stall_duty   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
			stall_pos    = 0;
		end
		out_stall <= (stall_pos < stall_duty);
		stall_pos = (stall_pos + 1) % stall_period;
		stall_cycle++;
	end

	// one tick word, sent in bursts with random gaps
	task automatic send_tick(input logic h, input logic v, input logic [DW-1:0] cm);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid      <= 1'b1;
		holding       <= h;
		reading_valid <= v;
		reading_cm    <= cm;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		burst_left--;
		tick_count++;
	endtask

	task automatic send_noise(input logic h);
		send_tick(h, 1'($urandom_range(0, 1)), DW'($urandom_range(0, CM_MAX)));
	endtask

	// stop sending and wait for every result word
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// full register set, unused upper data bits random, plus a dropped write
	task automatic program_regs(input logic [7:0] c, input logic [7:0] l, input logic [7:0] r,
			input logic [7:0] s, input logic [7:0] m, input logic [11:0] clr);
		write_reg(CFG_CENTER, {4'($urandom), c});
		write_reg(CFG_LEFT, {4'($urandom), l});
		write_reg(CFG_RIGHT, {4'($urandom), r});
		write_reg(CFG_SETTLE, {4'($urandom), s});
		write_reg(CFG_MARGIN, {4'($urandom), m});
		write_reg(CFG_CLEAR, clr);
		write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 12'($urandom));
		cfg_valid <= 1'b0;
		cur_settle = int'(s);
		cur_margin = int'(m);
		cur_clear  = int'(clr);
	endtask

	// idle tick, then holding high with chosen readings on the sample ticks
	task automatic run_scan(input int w, input int len,
			input logic cv, input logic [DW-1:0] ccm,
			input logic lv, input logic [DW-1:0] lcm,
			input logic rv, input logic [DW-1:0] rcm);
		send_noise(1'b0);
		for (int t = 0; t < len; t++) begin
			if (t == 2 + w)
				send_tick(1'b1, cv, ccm);
			else if (t == 4 + 2 * w)
				send_tick(1'b1, lv, lcm);
			else if (t == 6 + 3 * w)
				send_tick(1'b1, rv, rcm);
			else
				send_noise(1'b1);
		end
	endtask

	function automatic logic [DW-1:0] to_cm(input int x);
		if (x < 0)
			return '0;
		if (x > CM_MAX)
			return DW'(CM_MAX);
		return x[DW-1:0];
	endfunction

	function automatic logic [7:0] rand_angle();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(181, 255));
		return 8'($urandom_range(0, 180));
	endfunction

	// side distances placed around the clear limit and the margin edges
	task automatic pick_sides(output logic lv, output logic [DW-1:0] lcm,
			output logic rv, output logic [DW-1:0] rcm);
		int base;
		int d;
		int lc;
		int rc;
		base = $urandom_range(0, cur_clear + 64);
		d = int'($urandom_range(0, 2)) - 1;
		case ($urandom_range(0, 5))
			0: begin
				lc = $urandom_range(0, CM_MAX);
				rc = $urandom_range(0, CM_MAX);
			end
			1: begin
				lc = (cur_clear == 0) ? 0 : $urandom_range(0, cur_clear - 1);
				rc = (cur_clear == 0) ? 0 : $urandom_range(0, cur_clear - 1);
			end
			2: begin
				rc = base;
				lc = base + cur_margin + d;
			end
			3: begin
				lc = base;
				rc = base + cur_margin + d;
			end
			4: begin
				lc = base;
				rc = base;
			end
			default: begin
				lc = $urandom_range(0, 1) * CM_MAX;
				rc = $urandom_range(0, 1) * CM_MAX;
			end
		endcase
		lcm = to_cm(lc);
		rcm = to_cm(rc);
		lv = ($urandom_range(0, 7) != 0);
		rv = ($urandom_range(0, 7) != 0);
	endtask

	initial begin
		int w;
		int len;
		int kind;
		logic cv, lv, rv;
		logic [DW-1:0] ccm, lcm, rcm;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: angle above 180, zero settle, widest margin, highest clear limit
		program_regs(8'd255, 8'd0, 8'd180, 8'd0, 8'd255, 12'd4095);
		// right wins by margin, then one complete-hold tick
		run_scan(1, 12, 1'b1, 12'd4095, 1'b1, 12'd0, 1'b1, 12'd4095);
		// invalid center, both sides at full scale: margin sum must not wrap
		run_scan(1, 11, 1'b0, 12'd4095, 1'b1, 12'd4095, 1'b1, 12'd4095);

		// random phases, each on a fresh register set
		for (int ph = 0; tick_count < 1175; ph++) begin
			drain();
			if (ph == 0)
				program_regs(CENTER_RST, LEFT_RST, RIGHT_RST, SETTLE_RST, MARGIN_RST, CLEAR_RST);
			else
				program_regs(rand_angle(), rand_angle(), rand_angle(),
					(ph == 2) ? 8'd255 :
					(ph % 4 == 3) ? 8'($urandom_range(4, 20)) : 8'($urandom_range(0, 3)),
					(ph == 1) ? 8'd0 : ($urandom_range(0, 3) == 0) ? 8'd255 :
					8'($urandom_range(0, 40)),
					(ph == 1) ? 12'd0 : ($urandom_range(0, 4) == 0) ? 12'd4095 :
					12'($urandom_range(0, 300)));
			w = (cur_settle == 0) ? 1 : cur_settle;
			if (cur_settle == 255) begin
				// longest wait: stop right after the center capture
				pick_sides(lv, lcm, rv, rcm);
				run_scan(w, 3 + w, 1'b1, DW'($urandom_range(0, CM_MAX)), lv, lcm, rv, rcm);
			end else begin
				for (int s = 0; s < 8; s++) begin
					kind = $urandom_range(0, 9);
					if (kind == 0) begin
						repeat ($urandom_range(1, 10)) send_noise(1'($urandom_range(0, 1)));
					end else begin
						cv  = ($urandom_range(0, 7) != 0);
						ccm = DW'($urandom_range(0, CM_MAX));
						pick_sides(lv, lcm, rv, rcm);
						len = 8 + 3 * w + $urandom_range(0, 4);
						// broken scan: hold drops part way
						if (kind == 1)
							len = $urandom_range(1, len - 1);
						run_scan(w, len, cv, ccm, lv, lcm, rv, rcm);
					end
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[servo_sweep_obstacle_scanner_core] OK");
		else
			$display("[servo_sweep_obstacle_scanner_core] ERROR");
		$finish;
	end

endmodule
